// ===== src/bhsv_pkg.sv =====
// Package with shared types and constants for the BGR to HSV converter.
package bhsv_pkg;

    localparam int HUE_FRAC = 6;
    localparam int HUE_W    = 15;
    localparam int SAT_W    = 16;
    localparam int CH_W     = 8;
    localparam int SAT_NUM_W = 24;
    localparam int HUE_NUM_W = 22;
    localparam int HUE60    = 60 << HUE_FRAC;
    localparam int HUE120   = 120 << HUE_FRAC;
    localparam int HUE240   = 240 << HUE_FRAC;
    localparam int HUE360   = 360 << HUE_FRAC;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;

    typedef enum logic [1:0] {
        CH_BLUE  = 2'd0,
        CH_GREEN = 2'd1,
        CH_RED   = 2'd2
    } chan_t;

    typedef struct packed {
        logic [CH_W-1:0] mx;
        logic [CH_W-1:0] spread;
        logic            neg;
        logic [CH_W-1:0] dmag;
        chan_t           which;
        logic            last;
    } cls_t;

endpackage

// ===== src/bhsv_front.sv =====
// Front stage: accept pixels, pick max/min channel and register classification.
module bhsv_front
    import bhsv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CH_W-1:0]  blue,
    input  logic [CH_W-1:0]  green,
    input  logic [CH_W-1:0]  red,
    input  logic             last_in,
    output logic             cls_valid,
    input  logic             cls_ready,
    output cls_t             cls
);

    cls_t cls_reg, cls_next;
    logic vld_reg;
    logic [CH_W-1:0] mn;
    logic [CH_W:0]   d;

    assign in_ready  = !vld_reg || cls_ready;
    assign cls_valid = vld_reg;
    assign cls       = cls_reg;

    always_comb
    begin
        cls_next.last = last_in;
        if (blue > green)
        begin
            if (blue > red)
            begin
                cls_next.mx = blue;
                cls_next.which = CH_BLUE;
                mn = (green < red) ? green : red;
            end
            else
            begin
                cls_next.mx = red;
                cls_next.which = CH_RED;
                mn = green;
            end
        end
        else if (green > red)
        begin
            cls_next.mx = green;
            cls_next.which = CH_GREEN;
            mn = (blue < red) ? blue : red;
        end
        else
        begin
            cls_next.mx = red;
            cls_next.which = CH_RED;
            mn = blue;
        end
        cls_next.spread = cls_next.mx - mn;
        case (cls_next.which)
            CH_RED:   d = {1'b0, green} - {1'b0, blue};
            CH_GREEN: d = {1'b0, blue} - {1'b0, red};
            default:  d = {1'b0, red} - {1'b0, green};
        endcase
        cls_next.neg  = d[CH_W];
        cls_next.dmag = d[CH_W] ? CH_W'(-d) : d[CH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cls_reg <= cls_next;
    end

endmodule

// ===== src/bhsv_queue.sv =====
// Short queue between classification and arithmetic.
module bhsv_queue
    import bhsv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cls_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output cls_t rd_data
);

    cls_t mem [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;
    logic wr, rd;

    assign wr_ready = cnt_reg != (QPTR_W+1)'(QDEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= wp_reg + 1'b1;
            if (rd)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wr_data;
    end

endmodule

// ===== src/bhsv_back.sv =====
// Back end: pipelined restoring dividers for saturation and hue, then combinational hue offset and output select.
module bhsv_back
    import bhsv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cls_valid,
    output logic              cls_ready,
    input  cls_t              cls,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HUE_W-1:0]  hue,
    output logic [SAT_W-1:0]  saturation,
    output logic [CH_W-1:0]   brightness,
    output logic              last_out
);

    localparam int NS = SAT_NUM_W;

    logic              v_reg   [NS+1];
    cls_t              c_reg   [NS+1];
    logic [NS-1:0]     sq_reg  [NS+1];
    logic [CH_W:0]     sr_reg  [NS+1];
    logic [NS-1:0]     hq_reg  [NS+1];
    logic [CH_W:0]     hr_reg  [NS+1];
    logic advance;
    logic [CH_W+1:0] st, ht;
    logic [NS-1:0] sn [NS];
    logic [NS-1:0] hn [NS];
    logic [CH_W:0] srn [NS];
    logic [CH_W:0] hrn [NS];
    logic [NS-1:0] snum, hnum;
    logic [HUE_W+1:0] hs;

    assign advance   = !v_reg[NS] || out_ready;
    assign cls_ready = advance;
    assign snum = NS'(cls.spread) * NS'(255 * 256);
    assign hnum = NS'(cls.dmag) * NS'(HUE60);

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            st = {sr_reg[i], sq_reg[i][NS-1]};
            sn[i] = {sq_reg[i][NS-2:0], 1'b0};
            if (st >= {2'b0, c_reg[i].mx})
            begin
                st = st - {2'b0, c_reg[i].mx};
                sn[i][0] = 1'b1;
            end
            srn[i] = st[CH_W:0];
            ht = {hr_reg[i], hq_reg[i][NS-1]};
            hn[i] = {hq_reg[i][NS-2:0], 1'b0};
            if (ht >= {2'b0, c_reg[i].spread})
            begin
                ht = ht - {2'b0, c_reg[i].spread};
                hn[i][0] = 1'b1;
            end
            hrn[i] = ht[CH_W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NS; i++)
                v_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            v_reg[0] <= cls_valid;
            for (int i = 1; i <= NS; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            c_reg[0]  <= cls;
            sq_reg[0] <= snum;
            hq_reg[0] <= hnum;
            sr_reg[0] <= '0;
            hr_reg[0] <= '0;
            for (int i = 1; i <= NS; i++)
            begin
                c_reg[i]  <= c_reg[i-1];
                sq_reg[i] <= sn[i-1];
                hq_reg[i] <= hn[i-1];
                sr_reg[i] <= srn[i-1];
                hr_reg[i] <= hrn[i-1];
            end
        end
    end

    always_comb
    begin
        case (c_reg[NS].which)
            CH_GREEN: hs = (HUE_W+2)'(HUE120);
            CH_BLUE:  hs = (HUE_W+2)'(HUE240);
            default:  hs = (HUE_W+2)'(HUE360);
        endcase
        if (c_reg[NS].neg)
            hs = hs - (HUE_W+2)'(hq_reg[NS]);
        else
        begin
            hs = hs + (HUE_W+2)'(hq_reg[NS]);
            if (c_reg[NS].which == CH_RED)
                hs = hs - (HUE_W+2)'(HUE360);
        end
        if (hs >= (HUE_W+2)'(HUE360))
            hs = hs - (HUE_W+2)'(HUE360);
    end

    assign out_valid  = v_reg[NS];
    assign brightness = c_reg[NS].mx;
    assign last_out   = c_reg[NS].last;
    assign saturation = (c_reg[NS].spread == '0) ? '0 : sq_reg[NS][SAT_W-1:0];
    assign hue        = (c_reg[NS].spread == '0) ? '0 : hs[HUE_W-1:0];

endmodule

// ===== src/bgr_to_hsv_pixel_top.sv =====
// Top level of the BGR to HSV pixel converter.
// One pixel per clock sustained while the output accepts; a result is valid once its input item
// has passed the classifier register, the queue memory, one divider load register, then 24
// stages of a bit-per-stage restoring divider for saturation and hue. Back-pressure stalls the
// divider pipeline; the 4-entry queue decouples it from the classifier.
module bgr_to_hsv_pixel_top
    import bhsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // blue, green, red
    input  logic        s_axis_tlast,  // last_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // hue, saturation, brightness, zero fill
    output logic        m_axis_tlast   // last_out
);

    logic f_valid, f_ready, q_valid, q_ready;
    cls_t f_cls, q_cls;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [CH_W-1:0]  brightness;

    bhsv_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .blue(s_axis_tdata[7:0]), .green(s_axis_tdata[15:8]), .red(s_axis_tdata[23:16]),
        .last_in(s_axis_tlast),
        .cls_valid(f_valid), .cls_ready(f_ready), .cls(f_cls)
    );

    bhsv_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cls),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cls)
    );

    bhsv_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cls_valid(q_valid), .cls_ready(q_ready), .cls(q_cls),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .hue(hue), .saturation(saturation), .brightness(brightness),
        .last_out(m_axis_tlast)
    );

    assign m_axis_tdata = {1'b0, brightness, saturation, hue};

`ifndef SYNTHESIS
    a_sat_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[38:31] == 8'd0 |-> m_axis_tdata[30:0] == 31'd0)
        else $error("black pixel gave nonzero hue or saturation");
    a_hue_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[14:0] < 15'(HUE360))
        else $error("hue out of range");
    a_sat_rng: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[30:15] <= 16'd65280)
        else $error("saturation out of range");
`endif

endmodule

// ===== test/bgr_to_hsv_pixel_top_tb.sv =====
// Testbench for the BGR to HSV pixel converter: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps

class hsv_scoreboard;
    typedef struct {
        logic [14:0] hue;
        logic [15:0] saturation;
        logic [7:0]  brightness;
        logic        last_out;
    } hsv_t;

    hsv_t pending_hsv[$];
    int   error_count;
    int   checked_count;

    function hsv_t convert_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lst);
        hsv_t        res;
        int          mx;
        int          mn;
        int          spread;
        int          diff;
        int          base;
        int          hue;
        bhsv_pkg::chan_t which;
        if (b > g)
        begin
            if (b > r)
            begin
                mx = b;
                which = bhsv_pkg::CH_BLUE;
                mn = (g < r) ? g : r;
            end
            else
            begin
                mx = r;
                which = bhsv_pkg::CH_RED;
                mn = g;
            end
        end
        else if (g > r)
        begin
            mx = g;
            which = bhsv_pkg::CH_GREEN;
            mn = (b < r) ? b : r;
        end
        else
        begin
            mx = r;
            which = bhsv_pkg::CH_RED;
            mn = b;
        end
        spread = mx - mn;
        hue = 0;
        res.saturation = 0;
        if (spread > 0)
        begin
            res.saturation = 16'((255 * 256 * spread) / mx);
            case (which)
                bhsv_pkg::CH_RED:
                begin
                    diff = int'(g) - int'(b);
                    base = 0;
                end
                bhsv_pkg::CH_GREEN:
                begin
                    diff = int'(b) - int'(r);
                    base = 120;
                end
                default:
                begin
                    diff = int'(r) - int'(g);
                    base = 240;
                end
            endcase
            hue = ((60 << bhsv_pkg::HUE_FRAC) * diff) / spread + (base << bhsv_pkg::HUE_FRAC);
            if (hue < 0)
                hue += 360 << bhsv_pkg::HUE_FRAC;
        end
        res.hue = 15'(hue);
        res.brightness = 8'(mx);
        res.last_out = lst;
        return res;
    endfunction

    function void note_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lst);
        pending_hsv.push_back(convert_pixel(b, g, r, lst));
    endfunction

    function void check_hsv(logic [39:0] data, logic lst);
        hsv_t want;
        checked_count++;
        if (pending_hsv.size() == 0)
        begin
            $error("unexpected item: data %h last %b", data, lst);
            error_count++;
            return;
        end
        want = pending_hsv.pop_front();
        if (data[14:0] !== want.hue)
        begin
            $error("hue: expected %0d, actual %0d", want.hue, data[14:0]);
            error_count++;
        end
        if (data[30:15] !== want.saturation)
        begin
            $error("saturation: expected %0d, actual %0d", want.saturation, data[30:15]);
            error_count++;
        end
        if (data[38:31] !== want.brightness)
        begin
            $error("brightness: expected %0d, actual %0d", want.brightness, data[38:31]);
            error_count++;
        end
        if (lst !== want.last_out)
        begin
            $error("last_out: expected %b, actual %b", want.last_out, lst);
            error_count++;
        end
    endfunction
endclass

module bgr_to_hsv_pixel_top_tb;
    localparam int RANDOM_PIXELS = 1680;
    localparam int STALL_LIMIT   = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    hsv_scoreboard hsv_board;
    int            stall_cycles;
    bit            quiet_sink;
    bit            timed_out;
    int            sent_pixels;

    bgr_to_hsv_pixel_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    initial
    begin
        hsv_board = new();
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            hsv_board.check_hsv(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (rst_n)
            m_axis_tready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 16);
        else
            m_axis_tready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("bgr_to_hsv_pixel_top_tb: done, errors");
            $finish;
        end
    end

    task automatic send_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r, logic lst,
                              bit steady);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r, g, b};
        s_axis_tlast <= lst;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        hsv_board.note_pixel(b, g, r, lst);
        sent_pixels++;
    endtask

    task automatic send_random_pixel(bit steady);
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        int         shape;
        b = 8'($urandom);
        g = 8'($urandom);
        r = 8'($urandom);
        shape = $urandom_range(9);
        if (shape == 0)
        begin
            g = b;
            r = b;
        end
        else if (shape == 1)
            g = b;
        else if (shape == 2)
            r = g;
        else if (shape == 3)
            r = b;
        send_pixel(b, g, r, $urandom_range(7) == 0, steady);
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        stall_cycles = 0;
        quiet_sink = 1'b0;
        timed_out = 1'b0;
        sent_pixels = 0;
        @(posedge rst_n);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd90, 8'd90, 8'd90, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd1, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd1, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd255, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd1, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd1, 1'b0, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd0, 1'b1, 1'b0);
        send_pixel(8'd0, 8'd1, 8'd1, 1'b0, 1'b0);
        send_pixel(8'd128, 8'd128, 8'd127, 1'b0, 1'b0);
        send_pixel(8'd170, 8'd85, 8'd170, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd1, 1'b0, 1'b0);
        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            quiet_sink = (i >= 600 && i < 900);
            send_random_pixel(i >= 600 && i < 900);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        while (hsv_board.pending_hsv.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        $display("covered %0d pixels incl. grey, ties, primaries and last flags; %0d results",
                 sent_pixels, hsv_board.checked_count);
        $display("random source and sink idling, with one stretch of full rate");
        if (hsv_board.error_count == 0 && hsv_board.pending_hsv.size() == 0)
            $display("bgr_to_hsv_pixel_top_tb: done, clean");
        else
            $display("bgr_to_hsv_pixel_top_tb: done, errors");
        $finish;
    end
endmodule
